FILE: rtl/core/tun_pkg.sv
`default_nettype none
package tun_pkg;

  // field widths
  localparam int unsigned COORD_BITS       = 16;
  localparam int unsigned NORMAL_FRAC_BITS = 14;

  // derived datapath widths
  localparam int unsigned DW  = COORD_BITS + 1;          // edge component
  localparam int unsigned PW  = 2 * DW;                  // edge product
  localparam int unsigned NW  = PW + 1;                  // cross product component
  localparam int unsigned MW  = 2 * COORD_BITS + 2;      // magnitude of a component
  localparam int unsigned HW  = MW / 2;                  // half magnitude
  localparam int unsigned SQW = 2 * MW;                  // square of a component
  localparam int unsigned SW  = SQW + 2;                 // sum of three squares
  localparam int unsigned RW  = SQW + 2 * NORMAL_FRAC_BITS;  // scaled residual
  localparam int unsigned PQW = SW + NORMAL_FRAC_BITS + 1;   // q * S
  localparam int unsigned TW  = SW + 2 * NORMAL_FRAC_BITS + 3; // trial term
  localparam int unsigned QW  = NORMAL_FRAC_BITS + 1;    // quotient magnitude
  localparam int unsigned OW  = NORMAL_FRAC_BITS + 2;    // output component

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
  } out_word_t;

  // one component in the root pipeline
  typedef struct packed {
    logic [RW-1:0]  r;    // m^2*2^2F - q^2*S
    logic [PQW-1:0] p;    // q*S
    logic [QW-1:0]  q;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic [SW-1:0] s;
    logic          zero;
    lane_t [2:0]   lanes;
  } root_pipe_t;

endpackage
`default_nettype wire

FILE: rtl/core/tun_root_stage.sv
`default_nettype none
module tun_root_stage
  import tun_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire root_pipe_t in_pipe,
  output logic            out_valid,
  output root_pipe_t      out_pipe
);

  logic       valid_r;
  root_pipe_t pipe_r;
  root_pipe_t pipe_nxt;

  // try setting quotient bit BIT in each lane:
  // (q+2^b)^2*S - q^2*S = 2^(b+1)*q*S + 2^2b*S
  always_comb begin
    logic [TW-1:0] trial;
    logic          fit;
    pipe_nxt = in_pipe;
    for (int l = 0; l < 3; l++) begin
      trial = (TW'(in_pipe.lanes[l].p) << (BIT + 1)) + (TW'(in_pipe.s) << (2 * BIT));
      fit   = trial <= TW'(in_pipe.lanes[l].r);
      if (fit) begin
        pipe_nxt.lanes[l].r = in_pipe.lanes[l].r - trial[RW-1:0];
        pipe_nxt.lanes[l].p = in_pipe.lanes[l].p + (PQW'(in_pipe.s) << BIT);
        pipe_nxt.lanes[l].q = in_pipe.lanes[l].q | (QW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    pipe_r <= pipe_nxt;
  end

  assign out_valid = valid_r;
  assign out_pipe  = pipe_r;

`ifndef SYNTH
  a_valid_follows : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid))
    else $error("root stage valid without input");
  a_sum_kept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pipe.s == $past(in_pipe.s))
    else $error("root stage altered sum of squares");
  a_residual_down : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pipe.lanes[0].r <= $past(in_pipe.lanes[0].r)) &&
                  (out_pipe.lanes[1].r <= $past(in_pipe.lanes[1].r)) &&
                  (out_pipe.lanes[2].r <= $past(in_pipe.lanes[2].r)))
    else $error("root stage residual grew");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/triangle_unit_normal.sv
`default_nettype none
// Unit normal of a triangle, fully pipelined.
// Pipeline: 5 cross product / square stages, 15 quotient bit stages and one output
// register between start and out_valid.
// Throughput: one word per cycle; busy stays low and results cannot be stalled.
// Reset (rst_n low, synchronous) clears all valid bits; words in flight are dropped.
module triangle_unit_normal
  import tun_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: edge vectors
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r, ex_r, ey_r, ez_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    dx_r <= DW'(in_word.a_x) - DW'(in_word.b_x);
    dy_r <= DW'(in_word.a_y) - DW'(in_word.b_y);
    dz_r <= DW'(in_word.a_z) - DW'(in_word.b_z);
    ex_r <= DW'(in_word.b_x) - DW'(in_word.c_x);
    ey_r <= DW'(in_word.b_y) - DW'(in_word.c_y);
    ez_r <= DW'(in_word.b_z) - DW'(in_word.c_z);
  end

  // stage 2: edge products dy*ez, dz*ey, dz*ex, dx*ez, dx*ey and dy*ex
  logic                 v2_r;
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    p_r[0] <= dy_r * ez_r;
    p_r[1] <= dz_r * ey_r;
    p_r[2] <= dz_r * ex_r;
    p_r[3] <= dx_r * ez_r;
    p_r[4] <= dx_r * ey_r;
    p_r[5] <= dy_r * ex_r;
  end

  // stage 3: cross product
  logic                 v3_r;
  logic signed [NW-1:0] n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    for (int l = 0; l < 3; l++) begin
      n_r[l] <= NW'(p_r[2*l]) - NW'(p_r[2*l+1]);
    end
  end

  // stage 4: magnitudes, squared as three half-width partial products
  logic           v4_r;
  logic           neg_r [3];
  logic [2*HW-1:0] hh_r [3];
  logic [2*HW-1:0] hl_r [3];
  logic [2*HW-1:0] ll_r [3];

  always_ff @(posedge clk) begin
    logic [MW-1:0] m;
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    for (int l = 0; l < 3; l++) begin
      m = n_r[l][NW-1] ? MW'(-n_r[l]) : MW'(n_r[l]);
      neg_r[l] <= n_r[l][NW-1];
      hh_r[l]  <= m[MW-1:HW] * m[MW-1:HW];
      hl_r[l]  <= m[MW-1:HW] * m[HW-1:0];
      ll_r[l]  <= m[HW-1:0] * m[HW-1:0];
    end
  end

  // stage 5: squares, their sum and the scaled residuals
  logic       v5_r;
  root_pipe_t p5_r;

  always_ff @(posedge clk) begin
    logic [SQW-1:0] sq [3];
    logic [SW-1:0]  s;
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    for (int l = 0; l < 3; l++) begin
      sq[l] = (SQW'(hh_r[l]) << MW) + (SQW'(hl_r[l]) << (HW + 1)) + SQW'(ll_r[l]);
    end
    s = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    p5_r.s    <= s;
    p5_r.zero <= s == '0;
    for (int l = 0; l < 3; l++) begin
      p5_r.lanes[l].r   <= RW'(sq[l]) << (2 * NORMAL_FRAC_BITS);
      p5_r.lanes[l].p   <= '0;
      p5_r.lanes[l].q   <= '0;
      p5_r.lanes[l].neg <= neg_r[l];
    end
  end

  // quotient bit stages, MSB first
  logic       sv [QW+1];
  root_pipe_t sp [QW+1];

  assign sv[0] = v5_r;
  assign sp[0] = p5_r;

  for (genvar g = 0; g < QW; g++) begin : g_root
    tun_root_stage #(
      .BIT(QW - 1 - g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sv[g]),
      .in_pipe  (sp[g]),
      .out_valid(sv[g+1]),
      .out_pipe (sp[g+1])
    );
  end

  // output register: sign applied, degenerate triangle forced to zero
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_word_nxt;
  logic [OW-1:0] comp [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (sp[QW].zero) begin
        comp[l] = '0;
      end else if (sp[QW].lanes[l].neg) begin
        comp[l] = OW'(0) - OW'(sp[QW].lanes[l].q);
      end else begin
        comp[l] = OW'(sp[QW].lanes[l].q);
      end
    end
    out_word_nxt.normal_x = comp[0];
    out_word_nxt.normal_y = comp[1];
    out_word_nxt.normal_z = comp[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv[QW];
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");
  a_out_follows : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(sv[QW]))
    else $error("result word without pipeline word");
  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.normal_x <= $signed(OW'(1) << NORMAL_FRAC_BITS)) &&
                  (out_word.normal_x >= -$signed(OW'(1) << NORMAL_FRAC_BITS)) &&
                  (out_word.normal_y <= $signed(OW'(1) << NORMAL_FRAC_BITS)) &&
                  (out_word.normal_y >= -$signed(OW'(1) << NORMAL_FRAC_BITS)) &&
                  (out_word.normal_z <= $signed(OW'(1) << NORMAL_FRAC_BITS)) &&
                  (out_word.normal_z >= -$signed(OW'(1) << NORMAL_FRAC_BITS)))
    else $error("normal component beyond unit range");
`endif

endmodule
`default_nettype wire
